### hdl/smpu_pkg.sv
// Package for the substring match positions unit.
// Holds the shared sizes, codes and payload structs; depends on nothing.
`default_nettype none

package smpu_pkg;

    // Sizes
    localparam int PATTERN_MAX = 16;
    localparam int TEXT_MAX    = 256;
    localparam int QUEUE_DEPTH = 4;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = $clog2(TEXT_MAX + 1);
    localparam int LEN_W       = 5;
    localparam int PIDX_W      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int START_W     = 8;
    localparam int TOTAL_W     = 9;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TOTAL_W-1:0] COUNT_LIMIT = {TOTAL_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    // Result kind codes
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              text_start;
        logic              text_end;
    } text_item_t;

    typedef struct packed {
        logic               result_kind;
        logic [START_W-1:0] match_start;
        logic [TOTAL_W-1:0] match_total;
        logic               found_any;
        logic               last_result;
    } result_item_t;

    // One classified byte waiting for the back end
    typedef struct packed {
        logic               matched;
        logic               text_end;
        logic [START_W-1:0] match_start;
        logic [TOTAL_W-1:0] match_total;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

### hdl/smpu_front.sv
// Front end: configuration registers, byte window, parallel pattern compare
// and per-text counters. Depends on smpu_pkg.
`default_nettype none

module smpu_front
    import smpu_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   accept,
    input  wire text_item_t             text_item,
    output logic                        enq,
    output work_t                       work
);

    logic [CFG_DATA_W-1:0] pattern_low_reg;
    logic [CFG_DATA_W-1:0] pattern_high_reg;
    logic [LEN_W-1:0]      pattern_length_reg;

    logic [BYTE_W-1:0]     window_reg  [PATTERN_MAX];
    logic [BYTE_W-1:0]     window_next [PATTERN_MAX];
    logic [BYTE_W-1:0]     pattern_bytes [16];

    logic [POS_W-1:0]      position_reg, position_next;
    logic [TOTAL_W-1:0]    count_reg, count_next;

    logic [POS_W-1:0]      pos_base;
    logic [TOTAL_W-1:0]    count_base;
    logic [LEN_W-1:0]      act_len;
    logic [LEN_W-1:0]      len_m1;
    logic                  in_range;
    logic                  long_enough;
    logic                  bytes_equal;
    logic                  matched;
    logic [POS_W:0]        start_full;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Split the pattern words into bytes
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            pattern_bytes[k]     = pattern_low_reg[k*BYTE_W +: BYTE_W];
            pattern_bytes[k + 8] = pattern_high_reg[k*BYTE_W +: BYTE_W];
        end
    end

    // Clamp the pattern length to 1..PATTERN_MAX
    always_comb
    begin
        if (pattern_length_reg == '0)
            act_len = LEN_W'(1);
        else if (pattern_length_reg > LEN_W'(PATTERN_MAX))
            act_len = LEN_W'(PATTERN_MAX);
        else
            act_len = pattern_length_reg;
        len_m1 = act_len - LEN_W'(1);
    end

    // Clear position and count on text start
    assign pos_base   = text_item.text_start ? '0 : position_reg;
    assign count_base = text_item.text_start ? '0 : count_reg;
    assign in_range   = (pos_base < POS_W'(TEXT_MAX));

    // Shift the new byte into the window
    always_comb
    begin
        window_next[0] = text_item.text_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
            window_next[i] = window_reg[i-1];
    end

    // Compare the newest bytes against the pattern, oldest to byte 0
    always_comb
    begin
        logic [LEN_W-1:0] diff;
        bytes_equal = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            diff = len_m1 - LEN_W'(i);
            if (LEN_W'(i) < act_len)
            begin
                if (window_next[i] != pattern_bytes[diff[PIDX_W-1:0]])
                    bytes_equal = 1'b0;
            end
        end
    end

    assign long_enough = ({1'b0, pos_base} + (POS_W+1)'(1)) >= (POS_W+1)'(act_len);
    assign matched     = in_range && long_enough && bytes_equal;
    assign start_full  = {1'b0, pos_base} + (POS_W+1)'(1) - (POS_W+1)'(act_len);

    // Advance position and count
    always_comb
    begin
        position_next = in_range ? pos_base + POS_W'(1) : pos_base;
        count_next    = count_base;
        if (matched && count_base != COUNT_LIMIT)
            count_next = count_base + TOTAL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            count_reg    <= '0;
        end
        else if (accept)
        begin
            position_reg <= position_next;
            count_reg    <= count_next;
        end
    end

    // Hold the window unless a byte inside the text limit arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
                window_reg[i] <= '0;
        end
        else if (accept && in_range)
            window_reg <= window_next;
    end

    // Queue only bytes that cause a result
    assign enq              = accept && (matched || text_item.text_end);
    assign work.matched     = matched;
    assign work.text_end    = text_item.text_end;
    assign work.match_start = start_full[START_W-1:0];
    assign work.match_total = count_next;

    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= POS_W'(TEXT_MAX))
        else $error("text position beyond limit");

endmodule

`default_nettype wire

### hdl/smpu_queue.sv
// Short queue of classified bytes between the front and back ends.
// Depends on smpu_pkg.
`default_nettype none

module smpu_queue
    import smpu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    enq,
    input  wire work_t   enq_data,
    input  wire logic    deq,
    output work_t        head,
    output queue_status_t status
);

    work_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    // Store the entry at the write pointer
    always_ff @(posedge clk)
    begin
        if (enq)
            entry_reg[wr_ptr_reg] <= enq_data;
    end

    always_comb
    begin
        count_next = count_reg;
        if (enq && !deq)
            count_next = count_reg + QCNT_W'(1);
        else if (!enq && deq)
            count_next = count_reg - QCNT_W'(1);
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq)
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + QPTR_W'(1));
            if (deq)
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + QPTR_W'(1));
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        enq |-> (!status.full || deq))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        deq |-> !status.empty)
        else $error("queue read while empty");

endmodule

`default_nettype wire

### hdl/smpu_back.sv
// Back end: turns each queued entry into one or two result beats.
// Depends on smpu_pkg.
`default_nettype none

module smpu_back
    import smpu_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire work_t         head,
    input  wire logic          head_valid,
    input  wire logic          pop,
    output logic               deq,
    output result_item_t       result_item
);

    // Set once the match beat of a match-plus-summary entry has gone
    logic phase_reg, phase_next;
    logic show_match;
    logic beat;

    assign show_match = head.matched && !phase_reg;
    assign beat       = pop && head_valid;
    assign deq        = beat && !(show_match && head.text_end);

    always_comb
    begin
        phase_next = phase_reg;
        if (beat)
            phase_next = !deq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 1'b0;
        else
            phase_reg <= phase_next;
    end

    // Build the result beat from the head entry
    assign result_item.result_kind = show_match ? KIND_MATCH : KIND_SUMMARY;
    assign result_item.match_start = show_match ? head.match_start : '0;
    assign result_item.match_total = head.match_total;
    assign result_item.found_any   = (head.match_total != '0);
    assign result_item.last_result = show_match ? !head.text_end : 1'b1;

    a_phase_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head_valid && head.matched && head.text_end))
        else $error("summary phase without a pending match-and-end entry");

    a_phase_done: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && pop) |=> !phase_reg)
        else $error("summary phase held after its beat");

endmodule

`default_nettype wire

### hdl/substring_match_positions_unit.sv
// Top level of the substring match positions unit.
// Ties front end, queue and back end together; depends on smpu_pkg.
//
// Finds every start position, overlapping ones included, of a 1 to 16 byte
// pattern in a byte stream. One text byte is taken per cycle while full is
// low: the front end shifts it into a 16 byte window and compares it against
// the pattern in parallel in that same cycle. A byte that ends a match gives a
// match beat, a byte flagged text_end gives a summary beat after it, so one
// byte causes zero, one or two result beats. Classified bytes wait in a four
// entry queue; the back end drains one result beat per cycle with pop, so full
// rises only when result beats are produced faster than they are popped.
// A byte's first result beat reaches the result ports in the cycle after the
// byte is taken when nothing older waits in the queue.
// Bytes beyond the 256th of a text are ignored but still end the text.
// Configuration is written with cfg_we and applies from the next byte on.
`default_nettype none

module substring_match_positions_unit
    import smpu_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   push,
    output logic                        full,
    input  wire text_item_t             text_item,
    output logic                        empty,
    input  wire logic                   pop,
    output result_item_t                result_item
);

    logic          accept;
    logic          enq;
    logic          deq;
    work_t         work;
    work_t         head;
    queue_status_t q_status;

    assign full   = q_status.full;
    assign empty  = q_status.empty;
    assign accept = push && !q_status.full;

    // Classify each byte
    smpu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .text_item (text_item),
        .enq       (enq),
        .work      (work)
    );

    // Buffer classified bytes
    smpu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (enq),
        .enq_data (work),
        .deq      (deq),
        .head     (head),
        .status   (q_status)
    );

    // Emit result beats
    smpu_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (!q_status.empty),
        .pop         (pop),
        .deq         (deq),
        .result_item (result_item)
    );

endmodule

`default_nettype wire
